>>> sv/pit_counter_port_emulation_defines.svh
// assertion macros for the interval timer port block
// used by the checker module only
`ifndef PIT_COUNTER_PORT_EMULATION_DEFINES_SVH
`define PIT_COUNTER_PORT_EMULATION_DEFINES_SVH

// same-cycle implication
`define PIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pit port check failed");

// next-cycle implication
`define PIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pit port check failed");

`endif

>>> sv/pit_pkg.sv
// shared types and constants for the interval timer port block
// no dependencies
package pit_pkg;

   localparam logic [21:0] StepNumerator = 22'd2443632;
   localparam logic [16:0] FullCount     = 17'h10000;
   localparam logic [15:0] SpeakerMin    = 16'd36;
   localparam logic [4:0]  DivLastBit    = 5'd21;

   localparam logic [1:0] OpTick  = 2'd0;
   localparam logic [1:0] OpRead  = 2'd1;
   localparam logic [1:0] OpWrite = 2'd2;

   localparam logic [1:0] PortZero    = 2'd0;
   localparam logic [1:0] PortTwo     = 2'd1;
   localparam logic [1:0] PortControl = 2'd2;

   // read/write byte sequencing field of the counter 2 control word
   localparam logic [1:0] RwLatch = 2'd0;
   localparam logic [1:0] RwLow   = 2'd1;
   localparam logic [1:0] RwHigh  = 2'd2;
   localparam logic [1:0] RwBoth  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic exec;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic div_need;
      logic div_last;
   } status_type;

endpackage

>>> sv/pit_ctrl.sv
// controller state machine for the interval timer port block
// depends on pit_pkg
module pit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pit_pkg::status_type status,
   output pit_pkg::cmd_type    cmd
);

   pit_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pit_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pit_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.div_need ? pit_pkg::ST_DIVIDE : pit_pkg::ST_RESPOND;
            end
         end
         pit_pkg::ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = pit_pkg::ST_RESPOND;
            end
         end
         pit_pkg::ST_RESPOND: begin
            if (rsp_tready) begin
               state_in = pit_pkg::ST_IDLE;
            end
         end
         default: state_in = pit_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd.exec     = 1'b0;
      cmd.div_step = 1'b0;
      unique case (state_ff)
         pit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.exec   = req_tvalid;
         end
         pit_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         pit_pkg::ST_RESPOND: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

>>> sv/pit_datapath.sv
// counter state, port decode and shared restoring divider
// depends on pit_pkg
module pit_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pit_pkg::cmd_type    cmd,
   output pit_pkg::status_type status,
   input  logic [1:0]          operation,
   input  logic [1:0]          port,
   input  logic [7:0]          data,
   output logic [7:0]          read_data,
   output logic                irq_pulse,
   output logic [16:0]         speaker_step,
   output logic [21:0]         dac_step
);

   logic [16:0] zero_reload_ff, zero_reload_in;
   logic [16:0] zero_buf_ff, zero_buf_in;
   logic [16:0] zero_elapsed_ff, zero_elapsed_in;
   logic [16:0] two_reload_ff, two_reload_in;
   logic [16:0] two_elapsed_ff, two_elapsed_in;
   logic [15:0] two_rlatch_ff, two_rlatch_in;
   logic [15:0] two_wlatch_ff, two_wlatch_in;
   logic [7:0]  two_control_ff, two_control_in;
   logic        two_need_ff, two_need_in;
   logic [16:0] speaker_ff, speaker_in;
   logic [21:0] dac_ff, dac_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        irq_ff, irq_in;
   // divider
   logic [16:0] rem_ff, rem_in;
   logic [21:0] quo_ff, quo_in;
   logic [16:0] den_ff, den_in;
   logic        tgt_dac_ff, tgt_dac_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        full_mode;
   logic [15:0] capture;
   logic [15:0] rlatch_eff;
   logic [17:0] rem_sh;
   logic [17:0] rem_sub;
   logic [16:0] zero_diff;
   logic [16:0] zero_v;
   logic [16:0] zero_tick;
   logic [16:0] two_tick;
   logic        start_two;
   logic        div_need;

   always_comb begin
      full_mode = (two_control_ff[3:1] == 3'd0) || (two_control_ff[3:1] == 3'd4);
      capture   = full_mode ? 16'(pit_pkg::FullCount - two_elapsed_ff)
                            : 16'(two_reload_ff - two_elapsed_ff);
      rlatch_eff = two_need_ff ? capture : two_rlatch_ff;
      zero_diff  = zero_reload_ff - zero_elapsed_ff;
      zero_v     = ({1'b0, data, zero_buf_ff[7:0]} == 17'd0) ? pit_pkg::FullCount
                                                            : {1'b0, data, zero_buf_ff[7:0]};
      zero_tick  = zero_elapsed_ff + 17'd1;
      two_tick   = two_elapsed_ff + 17'd1;
      rem_sh     = {rem_ff, quo_ff[21]};
      rem_sub    = rem_sh - {1'b0, den_ff};
   end

   always_comb begin
      zero_reload_in  = zero_reload_ff;
      zero_buf_in     = zero_buf_ff;
      zero_elapsed_in = zero_elapsed_ff;
      two_reload_in   = two_reload_ff;
      two_elapsed_in  = two_elapsed_ff;
      two_rlatch_in   = two_rlatch_ff;
      two_wlatch_in   = two_wlatch_ff;
      two_control_in  = two_control_ff;
      two_need_in     = two_need_ff;
      speaker_in      = speaker_ff;
      dac_in          = dac_ff;
      rdata_in        = rdata_ff;
      irq_in          = irq_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      den_in          = den_ff;
      tgt_dac_in      = tgt_dac_ff;
      cnt_in          = cnt_ff;
      start_two       = 1'b0;
      div_need        = 1'b0;

      // decode of the incoming word
      if (operation == pit_pkg::OpTick) begin
         if (zero_tick >= zero_reload_ff) begin
            zero_elapsed_in = 17'd0;
            irq_in          = 1'b1;
         end else begin
            zero_elapsed_in = zero_tick;
            irq_in          = 1'b0;
         end
         two_elapsed_in = (two_tick >= two_reload_ff) ? 17'd0 : two_tick;
         rdata_in = 8'd0;
      end else begin
         irq_in   = 1'b0;
         rdata_in = 8'd0;
         if (operation == pit_pkg::OpRead && port == pit_pkg::PortZero) begin
            if (zero_buf_ff[16]) begin
               zero_buf_in = {1'b0, zero_buf_ff[15:8], 8'd0};
               rdata_in    = zero_buf_ff[15:8];
            end else if (zero_elapsed_ff >= zero_reload_ff) begin
               zero_buf_in = 17'h10001;
               rdata_in    = 8'd1;
            end else begin
               zero_buf_in = {1'b1, zero_diff[15:0]};
               rdata_in    = zero_diff[7:0];
            end
         end else if (operation == pit_pkg::OpRead && port == pit_pkg::PortTwo) begin
            two_rlatch_in = rlatch_eff;
            two_need_in   = 1'b0;
            case (two_control_ff[5:4])
               pit_pkg::RwLatch: begin
                  two_need_in       = 1'b1;
                  two_control_in    = two_control_ff | 8'h30;
                  rdata_in          = rlatch_eff[15:8];
               end
               pit_pkg::RwLow: begin
                  two_need_in = 1'b1;
                  rdata_in    = rlatch_eff[7:0];
               end
               pit_pkg::RwHigh: begin
                  two_need_in = 1'b1;
                  rdata_in    = rlatch_eff[15:8];
               end
               default: begin
                  two_control_in = two_control_ff & 8'hCF;
                  rdata_in       = rlatch_eff[7:0];
               end
            endcase
         end else if (operation == pit_pkg::OpWrite && port == pit_pkg::PortZero) begin
            if (zero_buf_ff[16]) begin
               zero_buf_in = {1'b0, data, zero_buf_ff[7:0]};
               if (zero_v != zero_reload_ff) begin
                  zero_reload_in  = zero_v;
                  zero_elapsed_in = 17'd0;
                  div_need        = 1'b1;
                  den_in          = zero_v;
                  tgt_dac_in      = 1'b1;
               end
            end else begin
               zero_buf_in = {1'b1, zero_buf_ff[15:8], data};
            end
         end else if (operation == pit_pkg::OpWrite && port == pit_pkg::PortTwo) begin
            case (two_control_ff[5:4])
               pit_pkg::RwLatch: begin
                  two_wlatch_in  = {data, two_wlatch_ff[7:0]};
                  two_control_in = two_control_ff | 8'h30;
                  start_two      = 1'b1;
               end
               pit_pkg::RwLow: begin
                  two_wlatch_in = {8'd0, data};
                  start_two     = 1'b1;
               end
               pit_pkg::RwHigh: begin
                  two_wlatch_in = {data, 8'd0};
                  start_two     = 1'b1;
               end
               default: begin
                  two_wlatch_in  = {two_wlatch_ff[15:8], data};
                  two_control_in = two_control_ff & 8'hCF;
               end
            endcase
         end else if (operation == pit_pkg::OpWrite && port == pit_pkg::PortControl) begin
            if (data[7] && !data[6]) begin
               if (data[5:4] != pit_pkg::RwLatch) begin
                  two_control_in = data;
               end else begin
                  two_rlatch_in = capture;
                  two_need_in   = 1'b0;
               end
            end
         end
      end

      // counter 2 restart; mode decides the wrap point
      if (start_two) begin
         if (full_mode) begin
            two_reload_in = pit_pkg::FullCount;
         end else begin
            two_reload_in = (two_wlatch_in == 16'd0) ? pit_pkg::FullCount
                                                     : {1'b0, two_wlatch_in};
         end
         two_elapsed_in = 17'd0;
         if (two_wlatch_in > pit_pkg::SpeakerMin) begin
            div_need   = 1'b1;
            den_in     = {1'b0, two_wlatch_in};
            tgt_dac_in = 1'b0;
         end else begin
            speaker_in = 17'd0;
         end
      end

      if (!cmd.exec) begin
         // hold everything the decode computed; only the divider may move
         zero_reload_in  = zero_reload_ff;
         zero_buf_in     = zero_buf_ff;
         zero_elapsed_in = zero_elapsed_ff;
         two_reload_in   = two_reload_ff;
         two_elapsed_in  = two_elapsed_ff;
         two_rlatch_in   = two_rlatch_ff;
         two_wlatch_in   = two_wlatch_ff;
         two_control_in  = two_control_ff;
         two_need_in     = two_need_ff;
         speaker_in      = speaker_ff;
         dac_in          = dac_ff;
         rdata_in        = rdata_ff;
         irq_in          = irq_ff;
         den_in          = den_ff;
         tgt_dac_in      = tgt_dac_ff;
      end else begin
         rem_in = 17'd0;
         quo_in = pit_pkg::StepNumerator;
         cnt_in = 5'd0;
      end

      // one quotient bit per cycle
      if (cmd.div_step) begin
         if (!rem_sub[17]) begin
            rem_in = rem_sub[16:0];
            quo_in = {quo_ff[20:0], 1'b1};
         end else begin
            rem_in = rem_sh[16:0];
            quo_in = {quo_ff[20:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == pit_pkg::DivLastBit) begin
            if (tgt_dac_ff) begin
               dac_in = quo_in;
            end else begin
               speaker_in = quo_in[16:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_reload_ff  <= pit_pkg::FullCount;
         zero_buf_ff     <= 17'd0;
         zero_elapsed_ff <= 17'd0;
         two_reload_ff   <= pit_pkg::FullCount;
         two_elapsed_ff  <= 17'd0;
         two_rlatch_ff   <= 16'd0;
         two_wlatch_ff   <= 16'd0;
         two_control_ff  <= 8'd0;
         two_need_ff     <= 1'b0;
         speaker_ff      <= 17'd0;
         dac_ff          <= 22'd0;
         cnt_ff          <= 5'd0;
      end else begin
         zero_reload_ff  <= zero_reload_in;
         zero_buf_ff     <= zero_buf_in;
         zero_elapsed_ff <= zero_elapsed_in;
         two_reload_ff   <= two_reload_in;
         two_elapsed_ff  <= two_elapsed_in;
         two_rlatch_ff   <= two_rlatch_in;
         two_wlatch_ff   <= two_wlatch_in;
         two_control_ff  <= two_control_in;
         two_need_ff     <= two_need_in;
         speaker_ff      <= speaker_in;
         dac_ff          <= dac_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff   <= rdata_in;
      irq_ff     <= irq_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      tgt_dac_ff <= tgt_dac_in;
   end

   assign status.div_need = div_need;
   assign status.div_last = (cnt_ff == pit_pkg::DivLastBit);
   assign read_data    = rdata_ff;
   assign irq_pulse    = irq_ff;
   assign speaker_step = speaker_ff;
   assign dac_step     = dac_ff;

endmodule

>>> sv/pit_counter_port_emulation.sv
// top level of the interval timer port block: counters 0 and 2 behind three byte ports
// depends on pit_pkg, pit_ctrl and pit_datapath
//
// one word in, one word out. a tick, a read or a write that needs no divide shows its
// result the cycle after accept; a write that reloads counter 0 with a new value, or
// starts counter 2 with a latch above 36, runs the shared restoring divider one
// quotient bit per cycle and shows its result once the last quotient bit is in. the
// block takes the next word only after the result has been taken. step outputs show
// the increment registers after the word.
module pit_counter_port_emulation (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [3:0]  req_tuser,   // [1:0] operation, [3:2] port
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [7:0] read_data, [8] irq_pulse,
                                    // [25:9] speaker_step, [47:26] dac_step
);

   pit_pkg::cmd_type    cmd;
   pit_pkg::status_type status;
   logic [7:0]          read_data;
   logic                irq_pulse;
   logic [16:0]         speaker_step;
   logic [21:0]         dac_step;

   // sequencing: accept, optional divide, hold result
   pit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // counters, port decode and divider
   pit_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .operation    (req_tuser[1:0]),
      .port         (req_tuser[3:2]),
      .data         (req_tdata),
      .read_data    (read_data),
      .irq_pulse    (irq_pulse),
      .speaker_step (speaker_step),
      .dac_step     (dac_step)
   );

   assign rsp_tdata = {dac_step, speaker_step, irq_pulse, read_data};

endmodule

>>> sv/pit_checker.sv
// port-level checks for the interval timer port block, bound to the top level
// depends on pit_counter_port_emulation_defines.svh
`include "pit_counter_port_emulation_defines.svh"

module pit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // one word in flight: no accept right after an accept
   `PIT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // a pending result blocks new input
   `PIT_ASSERT_NOW(a_resp_blocks_req, clock, reset, rsp_tvalid, !req_tready)
   // a stalled result holds
   `PIT_ASSERT_NEXT(a_resp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   // a tick never returns read data
   `PIT_ASSERT_NOW(a_irq_no_read, clock, reset, rsp_tvalid && rsp_tdata[8],
                   rsp_tdata[7:0] == 8'd0)

endmodule

bind pit_counter_port_emulation pit_checker u_pit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/tb_pit_counter_port_emulation.sv
// self-checking bench for the interval timer port block: directed table then random words
// depends on pit_pkg and pit_counter_port_emulation
module tb_pit_counter_port_emulation;

   // control words used by the stimulus
   localparam logic [7:0] CwTwoBothMode3 = 8'hB6;
   localparam logic [7:0] CwTwoBothMode0 = 8'hB0;
   localparam logic [7:0] CwTwoLowMode2  = 8'h94;
   localparam logic [7:0] CwTwoHighMode4 = 8'hA8;
   localparam logic [7:0] CwTwoLatch     = 8'h86;
   localparam logic [7:0] CwReadBack     = 8'hC0;
   localparam logic [7:0] CwZeroSelect   = 8'h34;
   localparam logic [1:0] OpUnused       = 2'd3;
   localparam logic [1:0] PortUnused     = 2'd3;
   localparam int         Limit          = 400000;
   localparam int         RandomWords    = 1300;

   // packed in the order of rsp_tdata, highest bits first
   typedef struct packed {
      logic [21:0] dac;
      logic [16:0] spk;
      logic        irq;
      logic [7:0]  rd;
   } result_type;

   typedef struct {
      logic [1:0] op;
      logic [1:0] port;
      logic [7:0] data;
      bit         known;    // expected word typed in below
      result_type res;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data
   logic [3:0]  req_tuser = '0;   // [1:0] operation, [3:2] port
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;        // [7:0] read_data, [8] irq, [25:9] speaker, [47:26] dac

   pit_counter_port_emulation dut (.*);

   always #10 clock = ~clock;

   // timer model state
   logic [16:0] c0_reload, c0_buf, c0_elapsed;
   logic [16:0] c2_reload, c2_elapsed;
   logic [15:0] c2_rlatch, c2_wlatch;
   logic [7:0]  c2_ctrl;
   logic        c2_need;
   logic [16:0] spk_step;
   logic [21:0] dac_step;

   result_type pending_words[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;     // no idling on either side while set
   bit  done = 0;

   function automatic bit c2_full();
      return c2_ctrl[3:1] == 3'd0 || c2_ctrl[3:1] == 3'd4;
   endfunction

   task automatic c2_capture();
      logic [16:0] r;
      if (c2_full()) begin
         c2_rlatch = 16'(pit_pkg::FullCount - c2_elapsed);
      end else begin
         r = (c2_reload != 0) ? c2_reload : pit_pkg::FullCount;
         c2_rlatch = 16'(r - (c2_elapsed % r));
      end
   endtask

   task automatic c2_start();
      if (c2_full()) c2_reload = pit_pkg::FullCount;
      else c2_reload = (c2_wlatch != 0) ? {1'b0, c2_wlatch} : pit_pkg::FullCount;
      c2_elapsed = 0;
      spk_step = (c2_wlatch > pit_pkg::SpeakerMin) ?
                 17'(pit_pkg::StepNumerator / c2_wlatch) : '0;
   endtask

   // advance the timer model by one word, return the word it produces
   task automatic timer_step(input logic [1:0] op, input logic [1:0] port,
                             input logic [7:0] d, output result_type res);
      logic [16:0] v;
      res = '0;
      if (op == pit_pkg::OpTick) begin
         c0_elapsed++;
         if (c0_elapsed >= c0_reload) begin
            c0_elapsed = 0;
            res.irq = 1;
         end
         c2_elapsed++;
         if (c2_elapsed >= c2_reload) c2_elapsed = 0;
      end else if (op == pit_pkg::OpRead && port == pit_pkg::PortZero) begin
         if (c0_buf[16]) begin
            res.rd = c0_buf[15:8];
            c0_buf = c0_buf & 17'h0FF00;
         end else begin
            if (c0_elapsed >= c0_reload) c0_buf = 17'h10001;
            else c0_buf = 17'h10000 | (c0_reload - c0_elapsed);
            res.rd = c0_buf[7:0];
         end
      end else if (op == pit_pkg::OpRead && port == pit_pkg::PortTwo) begin
         if (c2_need) begin
            c2_capture();
            c2_need = 0;
         end
         case (c2_ctrl[5:4])
            pit_pkg::RwLatch: begin
               c2_need = 1; c2_ctrl[5:4] = pit_pkg::RwBoth; res.rd = c2_rlatch[15:8];
            end
            pit_pkg::RwLow:  begin c2_need = 1; res.rd = c2_rlatch[7:0]; end
            pit_pkg::RwHigh: begin c2_need = 1; res.rd = c2_rlatch[15:8]; end
            default: begin c2_ctrl[5:4] = pit_pkg::RwLatch; res.rd = c2_rlatch[7:0]; end
         endcase
      end else if (op == pit_pkg::OpWrite && port == pit_pkg::PortZero) begin
         if (c0_buf[16]) begin
            c0_buf = {1'b0, d, c0_buf[7:0]};
            v = (c0_buf != 0) ? c0_buf : pit_pkg::FullCount;
            if (v != c0_reload) begin
               c0_reload = v;
               dac_step = 22'(pit_pkg::StepNumerator / v);
               c0_elapsed = 0;
            end
         end else begin
            c0_buf = {1'b1, c0_buf[15:8], d};
         end
      end else if (op == pit_pkg::OpWrite && port == pit_pkg::PortTwo) begin
         case (c2_ctrl[5:4])
            pit_pkg::RwLatch: begin
               c2_wlatch[15:8] = d; c2_ctrl[5:4] = pit_pkg::RwBoth; c2_start();
            end
            pit_pkg::RwLow:  begin c2_wlatch = {8'h00, d}; c2_start(); end
            pit_pkg::RwHigh: begin c2_wlatch = {d, 8'h00}; c2_start(); end
            default: begin c2_wlatch[7:0] = d; c2_ctrl[5:4] = pit_pkg::RwLatch; end
         endcase
      end else if (op == pit_pkg::OpWrite && port == pit_pkg::PortControl) begin
         // read-back code and counter 0/1 selects are ignored
         if (d[7:6] == 2'b10) begin
            if (d[5:4] != pit_pkg::RwLatch) c2_ctrl = d;
            else begin
               c2_capture();
               c2_need = 0;
            end
         end
      end
      res.spk = spk_step;
      res.dac = dac_step;
   endtask

   // directed rows; the first few come straight from reset values
   row_type rows[$];
   task automatic add_row(logic [1:0] op, logic [1:0] port, logic [7:0] d,
                          bit known = 0, logic [7:0] rd = 0, logic irq = 0);
      row_type r;
      r.op = op; r.port = port; r.data = d; r.known = known;
      r.res = '{rd: rd, irq: irq, spk: '0, dac: '0};
      rows.push_back(r);
   endtask

   task automatic build_rows();
      add_row(pit_pkg::OpTick, pit_pkg::PortZero, 8'hFF, 1);       // tick straight after reset
      add_row(OpUnused, pit_pkg::PortTwo, 8'hFF, 1);               // unused operation
      add_row(pit_pkg::OpRead, PortUnused, 8'h00, 1);              // unused port reads zero
      add_row(pit_pkg::OpWrite, PortUnused, 8'hFF, 1);             // unused port write dropped
      add_row(pit_pkg::OpWrite, pit_pkg::PortControl, CwReadBack, 1);   // read-back ignored
      add_row(pit_pkg::OpWrite, pit_pkg::PortControl, CwZeroSelect, 1); // counter 0 ignored
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'h00);         // 0 = 65536, same value
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'h02);         // new reload 2
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpTick, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpTick, pit_pkg::PortZero, 8'h00);          // irq
      add_row(pit_pkg::OpRead, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpRead, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpWrite, pit_pkg::PortControl, CwTwoBothMode3);
      add_row(pit_pkg::OpWrite, pit_pkg::PortTwo, 8'h24);          // latch 36, speaker forced 0
      add_row(pit_pkg::OpWrite, pit_pkg::PortTwo, 8'h00);
      add_row(pit_pkg::OpWrite, pit_pkg::PortTwo, 8'h25);          // latch 37
      add_row(pit_pkg::OpWrite, pit_pkg::PortTwo, 8'h00);
      add_row(pit_pkg::OpTick, pit_pkg::PortZero, 8'h00);
      add_row(pit_pkg::OpWrite, pit_pkg::PortControl, CwTwoLatch); // counter latch command
      add_row(pit_pkg::OpRead, pit_pkg::PortTwo, 8'h00);
      add_row(pit_pkg::OpRead, pit_pkg::PortTwo, 8'h00);
      add_row(pit_pkg::OpWrite, pit_pkg::PortControl, CwTwoHighMode4);
      add_row(pit_pkg::OpWrite, pit_pkg::PortTwo, 8'hFF);
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'hFF);
      add_row(pit_pkg::OpWrite, pit_pkg::PortZero, 8'hFF);         // reload 65535
   endtask

   // random word: ticks most often, with small reloads so counters wrap often
   task automatic pick_word(output logic [1:0] op, output logic [1:0] port,
                            output logic [7:0] d);
      int k;
      k = $urandom_range(99);
      op = pit_pkg::OpTick; port = 2'($urandom); d = 8'($urandom);
      if (k < 45) begin
         op = pit_pkg::OpTick;
      end else if (k < 65) begin
         op = pit_pkg::OpRead;
         port = ($urandom_range(9) == 0) ? PortUnused : 2'($urandom_range(1));
      end else if (k < 80) begin
         op = pit_pkg::OpWrite;
         port = 2'($urandom_range(1));
         if ($urandom_range(3) != 0) d = 8'($urandom_range(12));
      end else if (k < 92) begin
         op = pit_pkg::OpWrite; port = pit_pkg::PortControl;
         case ($urandom_range(6))
            0: d = CwTwoBothMode3;
            1: d = CwTwoBothMode0;
            2: d = CwTwoLowMode2;
            3: d = CwTwoHighMode4;
            4: d = CwTwoLatch;
            5: d = {2'b10, 2'($urandom), 4'($urandom)};
            default: d = 8'($urandom);
         endcase
      end else if (k < 96) begin
         op = pit_pkg::OpWrite; port = 2'($urandom);
      end else begin
         op = OpUnused;
      end
   endtask

   // send one word, predict on accept
   task automatic send_word(logic [1:0] op, logic [1:0] port, logic [7:0] d,
                            bit known, result_type typed);
      result_type exp_word;
      while (!quiet && $urandom_range(99) < 17) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      req_tuser  <= {port, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      timer_step(op, port, d, exp_word);
      pending_words.push_back(known ? typed : exp_word);
      @(negedge clock);
   endtask

   // result side: random stall, compare on accept
   always @(negedge clock) begin
      if (!reset) rsp_tready <= quiet || ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            want = pending_words.pop_front();
            if (got.rd !== want.rd || got.irq !== want.irq ||
                got.spk !== want.spk || got.dac !== want.dac) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch rd %h/%h irq %b/%b spk %0d/%0d dac %0d/%0d",
                           want.rd, got.rd, want.irq, got.irq,
                           want.spk, got.spk, want.dac, got.dac);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > Limit && !done) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [1:0] op, port;
      logic [7:0] d;
      c0_reload = pit_pkg::FullCount; c0_buf = 0; c0_elapsed = 0;
      c2_reload = pit_pkg::FullCount; c2_elapsed = 0; c2_rlatch = 0; c2_wlatch = 0;
      c2_ctrl = 0; c2_need = 0; spk_step = 0; dac_step = 0;
      build_rows();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      foreach (rows[i]) send_word(rows[i].op, rows[i].port, rows[i].data,
                                  rows[i].known, rows[i].res);
      for (int n = 0; n < RandomWords; n++) begin
         quiet = (n >= 500 && n < 700);
         pick_word(op, port, d);
         send_word(op, port, d, 0, '0);
      end
      quiet = 0;
      req_tvalid <= 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      done = 1;
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
